// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, sampled on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge out of reset.
`define BPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is never true at a clock edge out of reset.
`define BPM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define BPM_ASSERT(lbl, prop, msg)
`define BPM_NEVER(lbl, cond, msg)

`endif

`endif

// ----- src/bpm_pkg.sv -----
package bpm_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 128;
	localparam int unsigned CHAR_W = 16;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned STATUS_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [1:0] {
		KIND_PAREN,
		KIND_SQUARE,
		KIND_CURLY,
		KIND_QUOTE
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SCANNING,
		ST_MATCHED,
		ST_WRONG_PAIR,
		ST_STRAY,
		ST_UNCLOSED,
		ST_OVERFLOW
	} status_t;

	// Stack operation issued by the scanner for one character.
	typedef struct packed {
		logic  upd;
		logic  clear;
		logic  push;
		logic  pop;
		kind_t kind;
	} stk_cmd_t;

	// What the scanner needs to see of the stack.
	typedef struct packed {
		logic  empty;
		logic  one;
		logic  full;
		kind_t top;
	} stk_view_t;

endpackage

// ----- src/bpm_if.sv -----
interface bpm_in_if;
	logic                        valid;
	logic                        ready;
	logic [bpm_pkg::CHAR_W-1:0]  char_code;
	logic                        range_last;

	modport source (output valid, output char_code, output range_last, input ready);
	modport sink (input valid, input char_code, input range_last, output ready);
endinterface

interface bpm_out_if;
	logic                          valid;
	logic                          ready;
	logic                          scan_done;
	logic [bpm_pkg::STATUS_W-1:0]  scan_status;
	logic                          bad_start;
	logic [bpm_pkg::CNT_W-1:0]     consumed_count;

	modport source (
		output valid, output scan_done, output scan_status,
		output bad_start, output consumed_count, input ready
	);
	modport sink (
		input valid, input scan_done, input scan_status,
		input bad_start, input consumed_count, output ready
	);
endinterface

// ----- src/bpm_stack.sv -----
`include "assert_macros.svh"

module bpm_stack #(
	parameter int unsigned STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpm_pkg::stk_cmd_t   cmd,
	output bpm_pkg::stk_view_t  view
);
	import bpm_pkg::*;

	localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam logic [LVL_W-1:0] LVL_ZERO = '0;
	localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
	localparam logic [LVL_W-1:0] LVL_TWO = LVL_W'(2);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

	// Top entry lives in top_q, the one below it in below_q; memory holds
	// entries 0 .. level-2 at their own index.
	kind_t            mem [STACK_DEPTH];
	kind_t            top_q;
	kind_t            below_q;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] level_nxt;
	logic [LVL_W-1:0] rd_lvl;
	logic [LVL_W-1:0] wr_lvl;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             do_push;
	logic             do_pop;
	logic             wr_en;

	assign do_push = cmd.upd && cmd.push && !cmd.clear;
	assign do_pop = cmd.upd && cmd.pop && !cmd.clear;

	always_comb begin
		priority if (cmd.clear) begin
			level_nxt = LVL_ZERO;
		end else if (do_push) begin
			level_nxt = level_q + LVL_ONE;
		end else if (do_pop) begin
			level_nxt = level_q - LVL_ONE;
		end else begin
			level_nxt = level_q;
		end
	end

	// Fetch the entry that will sit below the new top.
	assign rd_lvl = level_nxt - LVL_TWO;
	assign rd_addr = rd_lvl[AW-1:0];
	// Spill the old top to its own index on a push.
	assign wr_lvl = level_q - LVL_ONE;
	assign wr_addr = wr_lvl[AW-1:0];
	assign wr_en = do_push && (level_q != LVL_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_ZERO;
		end else if (cmd.upd) begin
			level_q <= level_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= top_q;
		end
		if (cmd.upd) begin
			// Bypass the memory when the entry below is the one being spilled.
			if (do_push) begin
				below_q <= top_q;
			end else begin
				below_q <= mem[rd_addr];
			end
		end
		if (do_push) begin
			top_q <= cmd.kind;
		end else if (do_pop) begin
			top_q <= below_q;
		end
	end

	assign view.empty = (level_q == LVL_ZERO);
	assign view.one = (level_q == LVL_ONE);
	assign view.full = (level_q == LVL_FULL);
	assign view.top = top_q;

	`BPM_NEVER(a_push_full, do_push && view.full, "push on a full stack")
	`BPM_NEVER(a_pop_empty, do_pop && view.empty, "pop on an empty stack")
	`BPM_ASSERT(a_push_top, do_push |=> (top_q == $past(cmd.kind)), "pushed kind not on top")
	`BPM_ASSERT(a_clear_empty, (cmd.upd && cmd.clear) |=> view.empty, "stack not empty after clear")
	`BPM_ASSERT(a_pop_level, do_pop |=> (level_q == $past(level_q) - LVL_ONE), "pop lost a level")

endmodule

// ----- src/bpm_scan.sv -----
module bpm_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  logic [bpm_pkg::CHAR_W-1:0]  char_s1,
	input  logic                        last_s1,
	output logic                        adv,
	output bpm_pkg::stk_cmd_t           cmd,
	input  bpm_pkg::stk_view_t          view,
	bpm_out_if.source                   results
);
	import bpm_pkg::*;

	logic             active_q;
	logic             skip_q;
	logic [CNT_W-1:0] cnt_q;
	logic             bad_q;

	logic             out_valid_q;
	logic             done_q;
	status_t          status_q;
	logic             bad_out_q;
	logic [CNT_W-1:0] cnt_out_q;

	logic             fire;
	logic [7:0]       lo;
	logic             is8;
	logic             is_open;
	logic             is_close;
	kind_t            open_k;
	kind_t            close_k;
	logic             is_bslash;
	logic             is_dq;
	logic             start_bad;
	logic             bad_cur;
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_nxt;
	logic             has_top;
	logic             quote_top;
	logic             push;
	logic             pop;
	logic             err;
	status_t          err_st;
	logic             skip_nxt;
	logic             empty_after;
	status_t          status;
	logic             done;

	assign adv = !out_valid_q || results.ready;
	assign fire = valid_s1 && adv;

	assign lo = char_s1[7:0];
	assign is8 = (char_s1[CHAR_W-1:8] == '0);

	always_comb begin
		is_open = 1'b0;
		is_close = 1'b0;
		open_k = KIND_PAREN;
		close_k = KIND_PAREN;
		if (is8) begin
			unique case (lo)
				CH_LPAREN: begin is_open = 1'b1; open_k = KIND_PAREN; end
				CH_LSQUARE: begin is_open = 1'b1; open_k = KIND_SQUARE; end
				CH_LCURLY: begin is_open = 1'b1; open_k = KIND_CURLY; end
				CH_DQUOTE: begin is_open = 1'b1; open_k = KIND_QUOTE; end
				CH_RPAREN: begin is_close = 1'b1; close_k = KIND_PAREN; end
				CH_RSQUARE: begin is_close = 1'b1; close_k = KIND_SQUARE; end
				CH_RCURLY: begin is_close = 1'b1; close_k = KIND_CURLY; end
				default: begin end
			endcase
		end
	end

	assign is_bslash = is8 && (lo == CH_BSLASH);
	assign is_dq = is8 && (lo == CH_DQUOTE);
	assign start_bad = !(is8 && (lo == CH_LPAREN || lo == CH_LSQUARE || lo == CH_LCURLY));

	// A character seen while idle opens a new scan.
	assign bad_cur = active_q ? bad_q : start_bad;
	assign cnt_base = active_q ? cnt_q : '0;
	assign cnt_nxt = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);

	assign has_top = !view.empty;
	assign quote_top = has_top && (view.top == KIND_QUOTE);

	always_comb begin
		push = 1'b0;
		pop = 1'b0;
		err = 1'b0;
		err_st = ST_WRONG_PAIR;
		skip_nxt = 1'b0;
		priority if (skip_q) begin
			skip_nxt = 1'b0;
		end else if (quote_top) begin
			if (is_bslash) begin
				skip_nxt = 1'b1;
			end else if (is_dq) begin
				pop = 1'b1;
			end
		end else if (is_open) begin
			if (view.full) begin
				err = 1'b1;
				err_st = ST_OVERFLOW;
			end else begin
				push = 1'b1;
			end
		end else if (is_close) begin
			if (has_top && (view.top == close_k)) begin
				pop = 1'b1;
			end else begin
				err = 1'b1;
				err_st = has_top ? ST_WRONG_PAIR : ST_STRAY;
			end
		end else begin
			skip_nxt = 1'b0;
		end
	end

	assign empty_after = (view.empty && !push) || (pop && view.one);

	always_comb begin
		priority if (err) begin
			status = err_st;
		end else if (empty_after) begin
			status = ST_MATCHED;
		end else if (last_s1) begin
			status = ST_UNCLOSED;
		end else begin
			status = ST_SCANNING;
		end
	end

	assign done = (status != ST_SCANNING);

	always_comb begin
		cmd.upd = fire;
		cmd.clear = done;
		cmd.push = push;
		cmd.pop = pop;
		cmd.kind = open_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			skip_q <= 1'b0;
			cnt_q <= '0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				active_q <= !done;
				skip_q <= skip_nxt && !done;
				cnt_q <= cnt_nxt;
				bad_q <= bad_cur;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			done_q <= done;
			status_q <= status;
			bad_out_q <= bad_cur;
			cnt_out_q <= cnt_nxt;
		end
	end

	assign results.valid = out_valid_q;
	assign results.scan_done = done_q;
	assign results.scan_status = status_q;
	assign results.bad_start = bad_out_q;
	assign results.consumed_count = cnt_out_q;

endmodule

// ----- src/bracket_pair_matcher.sv -----
// Bracket pair matcher: takes one UTF-16 code unit per transaction on the
// chars channel (char_code, range_last) and returns one result per character
// on the results channel (scan_done, scan_status, bad_start, consumed_count).
// A scan starts with the first character after reset or after a finished
// scan, tracks ( [ { and string quotes on a stack, and ends when the stack
// empties, on an error, or at the range's last character.
// Each accepted character is registered in the input register (valid_s1,
// char_s1, last_s1); its result is then registered in the result register
// that drives results, and is held there until it is taken.
// Throughput: one character per cycle while results is not stalled; the
// top two stack entries are registers; no push or pop waits on a memory read.
// Reset clears the scan state and the stack level; the stack memory keeps
// its contents, and no character needs to wait after reset.
// When results is stalled, the pending result holds and one further character
// is held in the input register; chars.ready then drops until results drains.
module bracket_pair_matcher #(
	parameter int unsigned STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bpm_in_if.sink      chars,
	bpm_out_if.source   results
);
	import bpm_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              adv;
	stk_cmd_t          cmd;
	stk_view_t         view;

	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.range_last;
		end
	end

	bpm_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.last_s1  (last_s1),
		.adv      (adv),
		.cmd      (cmd),
		.view     (view),
		.results  (results)
	);

	bpm_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.view   (view)
	);

endmodule

// ----- tb/bracket_pair_matcher_tb.sv -----
module bracket_pair_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpm_pkg::*;

	localparam int unsigned DEPTH = STACK_DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLDOFF_CYCLES = 400;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	typedef struct packed {
		logic              done;
		status_t           status;
		logic              bad;
		logic [CNT_W-1:0]  count;
	} scan_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpm_in_if  chars_bus ();
	bpm_out_if result_bus ();

	bracket_pair_matcher #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_bus),
		.results(result_bus)
	);

	always #10 clk = ~clk;

	char_item_t chars_due[$];
	scan_res_t  results_due[$];
	int         queued = 0;
	int         mismatch_cnt = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         quiet_cycles = 0;
	logic       hold_go = 1'b0;
	logic       hold_used;
	int         hold_left;

	// Predictor state
	kind_t            open_kinds [DEPTH];
	int               level = 0;
	logic             skip = 1'b0;
	logic             scan_on = 1'b0;
	logic [CNT_W-1:0] used = '0;
	logic             bad_first = 1'b0;

	function automatic logic [CHAR_W-1:0] wide(input logic [7:0] b);
		return {8'h00, b};
	endfunction

	function automatic int opener_of(input logic [CHAR_W-1:0] c);
		case (c)
			wide(CH_LPAREN): return int'(KIND_PAREN);
			wide(CH_LSQUARE): return int'(KIND_SQUARE);
			wide(CH_LCURLY): return int'(KIND_CURLY);
			wide(CH_DQUOTE): return int'(KIND_QUOTE);
			default: return -1;
		endcase
	endfunction

	function automatic int closer_of(input logic [CHAR_W-1:0] c);
		case (c)
			wide(CH_RPAREN): return int'(KIND_PAREN);
			wide(CH_RSQUARE): return int'(KIND_SQUARE);
			wide(CH_RCURLY): return int'(KIND_CURLY);
			default: return -1;
		endcase
	endfunction

	task automatic predict_scan(input logic [CHAR_W-1:0] c, input logic last,
			output scan_res_t res);
		status_t st;
		logic    err;
		int      top;
		int      ok;
		int      ck;
		st = ST_SCANNING;
		err = 1'b0;
		if (!scan_on) begin
			scan_on = 1'b1;
			level = 0;
			skip = 1'b0;
			used = '0;
			bad_first = !(c == wide(CH_LPAREN) || c == wide(CH_LSQUARE) ||
				c == wide(CH_LCURLY));
		end
		if (used != CNT_MAX)
			used++;
		top = (level == 0) ? -1 : int'(open_kinds[level-1]);
		ok = opener_of(c);
		ck = closer_of(c);
		if (skip) begin
			skip = 1'b0;
		end else if (top == int'(KIND_QUOTE)) begin
			// inside a string only escape and closing quote count
			if (c == wide(CH_BSLASH))
				skip = 1'b1;
			else if (c == wide(CH_DQUOTE))
				level--;
		end else if (ok >= 0) begin
			if (level >= DEPTH) begin
				st = ST_OVERFLOW;
				err = 1'b1;
			end else begin
				open_kinds[level] = kind_t'(ok);
				level++;
			end
		end else if (ck >= 0) begin
			if (top == ck) begin
				level--;
			end else begin
				st = (top < 0) ? ST_STRAY : ST_WRONG_PAIR;
				err = 1'b1;
			end
		end
		if (err) begin
			level = 0;
			skip = 1'b0;
		end else if (level == 0) begin
			st = ST_MATCHED;
		end else if (last) begin
			st = ST_UNCLOSED;
		end
		res.done = (st != ST_SCANNING);
		res.status = st;
		res.bad = bad_first;
		res.count = used;
		if (st != ST_SCANNING) begin
			scan_on = 1'b0;
			level = 0;
			skip = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Driver: offer the next pending character, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin : drive
		char_item_t item;
		scan_res_t  res;
		if (!arst_n) begin
			chars_bus.valid <= 1'b0;
			chars_bus.char_code <= '0;
			chars_bus.range_last <= 1'b0;
		end else begin
			if (chars_bus.valid && chars_bus.ready) begin
				predict_scan(chars_bus.char_code, chars_bus.range_last, res);
				results_due.push_back(res);
			end
			if (!chars_bus.valid || chars_bus.ready) begin
				if (chars_due.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item = chars_due.pop_front();
					chars_bus.valid <= 1'b1;
					chars_bus.char_code <= item.code;
					chars_bus.range_last <= item.last;
				end else begin
					chars_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_left <= HOLDOFF_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		scan_res_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected result (consumed_count)",
						result_bus.consumed_count, 0);
				end else begin
					want = results_due.pop_front();
					if (result_bus.scan_done !== want.done)
						flag_mismatch("scan_done", result_bus.scan_done, want.done);
					if (result_bus.scan_status !== want.status)
						flag_mismatch("scan_status", result_bus.scan_status, want.status);
					if (result_bus.bad_start !== want.bad)
						flag_mismatch("bad_start", result_bus.bad_start, want.bad);
					if (result_bus.consumed_count !== want.count)
						flag_mismatch("consumed_count", result_bus.consumed_count,
							want.count);
				end
			end
			result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (chars_bus.valid && chars_bus.ready) ||
				(result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic enqueue_char(input logic [CHAR_W-1:0] c, input logic last);
		chars_due.push_back('{code: c, last: last});
		queued++;
	endtask

	function automatic logic [CHAR_W-1:0] filler();
		logic [CHAR_W-1:0] c;
		c = CHAR_W'($urandom_range(0, 65535));
		if (c[15:8] == 8'h00 && c[7:0] inside {CH_LPAREN, CH_RPAREN, CH_LSQUARE,
				CH_RSQUARE, CH_LCURLY, CH_RCURLY, CH_DQUOTE, CH_BSLASH})
			c ^= 16'h0100;
		return c;
	endfunction

	function automatic logic [7:0] open_char(input kind_t k);
		case (k)
			KIND_PAREN: return CH_LPAREN;
			KIND_SQUARE: return CH_LSQUARE;
			KIND_CURLY: return CH_LCURLY;
			default: return CH_DQUOTE;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input kind_t k);
		case (k)
			KIND_PAREN: return CH_RPAREN;
			KIND_SQUARE: return CH_RSQUARE;
			KIND_CURLY: return CH_RCURLY;
			default: return CH_DQUOTE;
		endcase
	endfunction

	function automatic kind_t any_bracket();
		return kind_t'($urandom_range(int'(KIND_PAREN), int'(KIND_CURLY)));
	endfunction

	// Mostly well-formed scan with random content, with some broken endings
	task automatic gen_scan();
		kind_t stk[$];
		kind_t k;
		int    steps;
		int    roll;
		steps = $urandom_range(1, 24);
		roll = $urandom_range(99);
		if (roll < 8) begin
			enqueue_char(filler(), 1'($urandom_range(1)));
			return;
		end else if (roll < 12) begin
			enqueue_char(wide(close_char(any_bracket())), 1'($urandom_range(1)));
			return;
		end else if (roll < 17) begin
			stk.push_back(KIND_QUOTE);
		end else begin
			stk.push_back(any_bracket());
		end
		enqueue_char(wide(open_char(stk[$])), 1'b0);
		for (int i = 0; i < steps && stk.size() != 0; i++) begin
			roll = $urandom_range(99);
			if (stk[$] == KIND_QUOTE) begin
				if (roll < 15) begin
					enqueue_char(wide(CH_BSLASH), 1'b0);
					enqueue_char((roll < 5) ? wide(CH_DQUOTE) :
						CHAR_W'($urandom_range(0, 65535)), 1'b0);
				end else if (roll < 35) begin
					enqueue_char(wide(CH_DQUOTE), 1'b0);
					void'(stk.pop_back());
				end else if (roll < 55) begin
					k = any_bracket();
					enqueue_char(wide($urandom_range(1) ? open_char(k) : close_char(k)),
						1'b0);
				end else begin
					enqueue_char(filler(), $urandom_range(99) < 2);
				end
			end else begin
				if (roll < 30 && stk.size() < 12) begin
					stk.push_back(kind_t'($urandom_range(int'(KIND_PAREN), int'(KIND_QUOTE))));
					enqueue_char(wide(open_char(stk[$])), 1'b0);
				end else if (roll < 60) begin
					enqueue_char(wide(close_char(stk[$])), $urandom_range(99) < 5);
					void'(stk.pop_back());
				end else if (roll < 92) begin
					enqueue_char(filler(), $urandom_range(99) < 2);
				end else if (roll < 96) begin
					k = kind_t'((int'(stk[$]) + $urandom_range(1, 2)) % 3);
					enqueue_char(wide(close_char(k)), 1'($urandom_range(1)));
					return;
				end else begin
					enqueue_char(CHAR_W'($urandom_range(0, 65535)), 1'b0);
				end
			end
		end
		if (stk.size() != 0) begin
			if ($urandom_range(99) < 65) begin
				while (stk.size() != 0)
					enqueue_char(wide(close_char(stk.pop_back())), 1'b0);
			end else begin
				enqueue_char(filler(), 1'b1);
			end
		end
	endtask

	// Nest to the given depth; past the stack depth the scan overflows
	task automatic gen_deep(input int depth);
		kind_t stk[$];
		for (int i = 0; i < depth; i++) begin
			stk.push_back((i == depth - 1) ?
				kind_t'($urandom_range(int'(KIND_PAREN), int'(KIND_QUOTE))) : any_bracket());
			enqueue_char(wide(open_char(stk[$])), 1'b0);
		end
		if (depth > DEPTH)
			return;
		if (stk[$] == KIND_QUOTE)
			enqueue_char(wide(CH_LPAREN), 1'b0);
		while (stk.size() != 0)
			enqueue_char(wide(close_char(stk.pop_back())), 1'b0);
	endtask

	task automatic drain();
		while (chars_due.size() != 0 || chars_bus.valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n,
			input int deep);
		int start;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = queued;
		if (deep != 0)
			gen_deep(deep);
		while (queued - start < n)
			gen_scan();
		drain();
	endtask

	task automatic load_directed();
		enqueue_char(wide(8'h78), 1'b0);          // plain character as start
		enqueue_char(wide(CH_RPAREN), 1'b0);      // closer as start
		enqueue_char(wide(CH_LPAREN), 1'b0);      // wrong pair beats range end
		enqueue_char(wide(CH_RSQUARE), 1'b1);
		enqueue_char(wide(CH_LPAREN), 1'b0);
		enqueue_char(wide(CH_LSQUARE), 1'b0);
		enqueue_char(wide(CH_LCURLY), 1'b0);
		enqueue_char(wide(CH_RCURLY), 1'b0);
		enqueue_char(wide(CH_RSQUARE), 1'b0);
		enqueue_char(wide(CH_RPAREN), 1'b0);
		enqueue_char(wide(CH_DQUOTE), 1'b0);      // string start with escaped quote
		enqueue_char(wide(8'h61), 1'b0);
		enqueue_char(wide(CH_BSLASH), 1'b0);
		enqueue_char(wide(CH_DQUOTE), 1'b0);
		enqueue_char(wide(CH_DQUOTE), 1'b0);
		enqueue_char(wide(CH_LPAREN), 1'b0);      // range ends on the skipped character
		enqueue_char(wide(CH_DQUOTE), 1'b0);
		enqueue_char(wide(CH_BSLASH), 1'b0);
		enqueue_char(wide(8'h78), 1'b1);
		enqueue_char(wide(CH_LCURLY), 1'b1);      // unclosed on a single opener
		enqueue_char(wide(CH_LSQUARE), 1'b0);     // emptied stack beats range end
		enqueue_char(wide(CH_RSQUARE), 1'b1);
		enqueue_char(16'h0128, 1'b0);             // high byte set: not a bracket
		enqueue_char(16'hFFFF, 1'b1);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		load_directed();
		run_phase(0, 0, 150, 0);
		run_phase(59, 0, 200, DEPTH);
		hold_go = 1'b1;
		run_phase(0, 59, 200, DEPTH + 1);
		run_phase(26, 26, 250, 0);
		run_phase(0, 0, 70, 0);

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
